@@ src/tgztf_pkg.sv @@
`timescale 1ns / 1ps

package tgztf_pkg;

  // Field widths fixed by the cell and result formats
  localparam int DIST_W     = 16;
  localparam int STATUS_W   = 8;
  localparam int COUNT_W    = 5;
  localparam int SKIP_W     = 4;
  localparam int STREAK_W   = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [COUNT_W-1:0]  COUNT_MAX = 5'd31;

  // Target status codes that count as a valid measurement
  localparam logic [STATUS_W-1:0] STATUS_VALID    = 8'd5;
  localparam logic [STATUS_W-1:0] STATUS_LOW_CONF = 8'd9;

  // Register defaults after reset
  localparam logic [SKIP_W-1:0]   SKIP_LEFT_RST   = 4'd2;
  localparam logic [SKIP_W-1:0]   SKIP_MID_RST    = 4'd1;
  localparam logic [SKIP_W-1:0]   SKIP_RIGHT_RST  = 4'd1;
  localparam logic [DIST_W-1:0]   MARKER_RST      = 16'hFFFF;
  localparam logic [STREAK_W-1:0] ENTER_THR_RST   = 4'd2;
  localparam logic [STREAK_W-1:0] STREAK_CAP_RST  = 4'd2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SKIP_LEFT   = 3'd0,
    REG_SKIP_MID    = 3'd1,
    REG_SKIP_RIGHT  = 3'd2,
    REG_MARKER      = 3'd3,
    REG_ENTER_THR   = 3'd4,
    REG_STREAK_CAP  = 3'd5
  } cfg_reg_t;

endpackage

@@ src/tof_grid_zone_temporal_filter_unit.sv @@
`timescale 1ns / 1ps

// Channel  | Direction | tdata (lowest bit up)                          | tuser         | tlast
// s_*      | in        | cell_row, cell_col, cell_distance, cell_status | sensor_select | frame_last
// m_*      | out       | zone_index, zone_distance, zone_valid_count,   | sensor_id     | result_last
//          |           | nearest_mm                                     |               |
// cfg_*    | in        | cfg_index selects a register, cfg_data is written on cfg_we
//
// One cell is taken per clock while s_tready is high. A cell is held in the input register
// and folded from there into the zone accumulators; a final cell also runs the temporal
// filter and loads a frame buffer of ZONE_COUNT results, which drain one per clock on m_*
// while m_tready is high. A final cell waits in the input register while the previous
// frame's results still drain, so s_tready drops when a frame ends before the previous
// frame's results have all been sent, including when m_tready holds those results back.
// Reset is synchronous: accumulators go to the default marker, streaks and hold flags clear.
module tof_grid_zone_temporal_filter_unit #(
  parameter int GRID_SIDE    = 8,
  parameter int ZONE_COUNT   = 4,
  parameter int SENSOR_COUNT = 3,
  localparam int SW       = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1,
  localparam int RW       = $clog2(GRID_SIDE),
  localparam int ZW       = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1,
  localparam int DW       = tgztf_pkg::DIST_W,
  localparam int CNW      = tgztf_pkg::COUNT_W,
  localparam int IN_BITS  = 2 * RW + DW + tgztf_pkg::STATUS_W,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = ZW + 2 * DW + CNW,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic clk,
  input  logic rst,
  // Stream in
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // cell_row, cell_col, cell_distance, cell_status
  input  logic [IN_W-1:0]              s_tdata,
  // sensor_select
  input  logic [SW-1:0]                s_tuser,
  input  logic                         s_tlast,
  // Stream out
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // zone_index, zone_distance, zone_valid_count, nearest_mm
  output logic [OUT_W-1:0]             m_tdata,
  // sensor_id
  output logic [SW-1:0]                m_tuser,
  output logic                         m_tlast,
  // Configuration write port
  input  logic                         cfg_we,
  input  logic [tgztf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tgztf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int STW     = tgztf_pkg::STREAK_W;
  localparam logic [ZW-1:0] LAST_ZONE = ZW'(ZONE_COUNT - 1);

  // Configuration registers
  logic [tgztf_pkg::SKIP_W-1:0] skip_left, skip_mid, skip_right;
  logic [DW-1:0]                marker;
  logic [STW-1:0]               enter_thr, streak_cap;

  // Input register
  logic                         in_valid;
  logic [SW-1:0]                in_sensor;
  logic [RW-1:0]                in_row, in_col;
  logic [DW-1:0]                in_dist;
  logic [tgztf_pkg::STATUS_W-1:0] in_status;
  logic                         in_last;

  // Zone accumulators
  logic [DW-1:0]  acc_min    [ZONE_COUNT];
  logic [DW-1:0]  acc_second [ZONE_COUNT];
  logic [CNW-1:0] acc_count  [ZONE_COUNT];
  logic [DW-1:0]  acc_min_next    [ZONE_COUNT];
  logic [DW-1:0]  acc_second_next [ZONE_COUNT];
  logic [CNW-1:0] acc_count_next  [ZONE_COUNT];

  // Temporal filter state per sensor and zone
  logic [STW-1:0] hist_streak [SENSOR_COUNT][ZONE_COUNT];
  logic           hist_ok     [SENSOR_COUNT][ZONE_COUNT];
  logic [DW-1:0]  hist_val    [SENSOR_COUNT][ZONE_COUNT];
  logic [CNW-1:0] hist_cnt    [SENSOR_COUNT][ZONE_COUNT];

  // Frame result buffer
  logic           ob_busy;
  logic [ZW-1:0]  ob_idx;
  logic [SW-1:0]  ob_sensor;
  logic [DW-1:0]  ob_nearest;
  logic [DW-1:0]  ob_dist [ZONE_COUNT];
  logic [CNW-1:0] ob_cnt  [ZONE_COUNT];

  // Per-zone filter results for the current frame
  logic [STW-1:0] streak_next [ZONE_COUNT];
  logic           ok_next     [ZONE_COUNT];
  logic           hold_load   [ZONE_COUNT];
  logic [DW-1:0]  zval        [ZONE_COUNT];
  logic [CNW-1:0] zcnt        [ZONE_COUNT];
  logic [DW-1:0]  nearest;

  logic           take_cell, sensor_ok, cell_ok, ob_free, frame_load;
  logic [tgztf_pkg::SKIP_W-1:0] skip_sel;

  // Handshake: a final cell waits while the buffer still drains
  assign ob_free    = !ob_busy || (m_tready && ob_idx == LAST_ZONE);
  assign sensor_ok  = int'(in_sensor) < SENSOR_COUNT;
  assign take_cell  = in_valid && !(in_last && sensor_ok && !ob_free);
  assign s_tready   = !in_valid || take_cell;
  assign frame_load = take_cell && in_last && sensor_ok;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_left  <= tgztf_pkg::SKIP_LEFT_RST;
      skip_mid   <= tgztf_pkg::SKIP_MID_RST;
      skip_right <= tgztf_pkg::SKIP_RIGHT_RST;
      marker     <= tgztf_pkg::MARKER_RST;
      enter_thr  <= tgztf_pkg::ENTER_THR_RST;
      streak_cap <= tgztf_pkg::STREAK_CAP_RST;
    end else if (cfg_we) begin
      unique case (tgztf_pkg::cfg_reg_t'(cfg_index))
        tgztf_pkg::REG_SKIP_LEFT:  skip_left  <= cfg_data[tgztf_pkg::SKIP_W-1:0];
        tgztf_pkg::REG_SKIP_MID:   skip_mid   <= cfg_data[tgztf_pkg::SKIP_W-1:0];
        tgztf_pkg::REG_SKIP_RIGHT: skip_right <= cfg_data[tgztf_pkg::SKIP_W-1:0];
        tgztf_pkg::REG_MARKER:     marker     <= cfg_data[DW-1:0];
        tgztf_pkg::REG_ENTER_THR:  enter_thr  <= cfg_data[STW-1:0];
        tgztf_pkg::REG_STREAK_CAP: streak_cap <= cfg_data[STW-1:0];
        default: ;
      endcase
    end
  end

  // Capture the incoming cell
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sensor <= s_tuser;
      in_row    <= s_tdata[RW-1:0];
      in_col    <= s_tdata[2*RW-1:RW];
      in_dist   <= s_tdata[2*RW+DW-1:2*RW];
      in_status <= s_tdata[2*RW+DW+tgztf_pkg::STATUS_W-1:2*RW+DW];
      in_last   <= s_tlast;
    end
  end

  // Qualify the cell: sensor, grid bounds, floor rows, status and distance range
  always_comb begin
    priority if (in_sensor == SW'(0)) begin
      skip_sel = skip_left;
    end else if (int'(in_sensor) == 1) begin
      skip_sel = skip_mid;
    end else begin
      skip_sel = skip_right;
    end
    cell_ok = sensor_ok && int'(in_row) < GRID_SIDE && int'(in_col) < GRID_SIDE &&
              int'(in_row) >= int'(skip_sel) &&
              (in_status == tgztf_pkg::STATUS_VALID ||
               in_status == tgztf_pkg::STATUS_LOW_CONF) &&
              !in_dist[DW-1] && in_dist != '0 && in_dist < marker;
  end

  // Fold the cell into its zone lane
  always_comb begin
    for (int z = 0; z < ZONE_COUNT; z++) begin
      acc_min_next[z]    = acc_min[z];
      acc_second_next[z] = acc_second[z];
      acc_count_next[z]  = acc_count[z];
      if (cell_ok && int'(in_col >> 1) == z) begin
        if (acc_count[z] != tgztf_pkg::COUNT_MAX) begin
          acc_count_next[z] = acc_count[z] + CNW'(1);
        end
        if (in_dist < acc_min[z]) begin
          acc_second_next[z] = acc_min[z];
          acc_min_next[z]    = in_dist;
        end else if (in_dist < acc_second[z]) begin
          acc_second_next[z] = in_dist;
        end
      end
    end
  end

  // Zone value and temporal filter for the final cell's sensor
  always_comb begin
    logic [DW-1:0]  cur;
    logic [STW-1:0] st;
    logic           ok;
    logic [DW-1:0]  hv;
    logic [CNW-1:0] hc;
    nearest = marker;
    for (int z = 0; z < ZONE_COUNT; z++) begin
      st = '0;
      ok = 1'b0;
      hv = '0;
      hc = '0;
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        if (int'(in_sensor) == s) begin
          st = hist_streak[s][z];
          ok = hist_ok[s][z];
          hv = hist_val[s][z];
          hc = hist_cnt[s][z];
        end
      end

      priority if (acc_count_next[z] == '0) begin
        cur = marker;
      end else if (acc_count_next[z] >= CNW'(2) && acc_second_next[z] != marker) begin
        cur = acc_second_next[z];
      end else begin
        cur = acc_min_next[z];
      end

      hold_load[z] = 1'b0;
      ok_next[z]   = ok;
      if (cur != marker) begin
        streak_next[z] = (st < streak_cap) ? st + STW'(1) : st;
        if (streak_next[z] >= enter_thr) begin
          hold_load[z] = 1'b1;
          ok_next[z]   = 1'b1;
          zval[z]      = cur;
          zcnt[z]      = acc_count_next[z];
        end else begin
          zval[z] = marker;
          zcnt[z] = '0;
        end
      end else begin
        streak_next[z] = (st != '0) ? st - STW'(1) : st;
        if (streak_next[z] != '0 && ok) begin
          zval[z] = hv;
          zcnt[z] = hc;
        end else begin
          zval[z]    = marker;
          zcnt[z]    = '0;
          ok_next[z] = 1'b0;
        end
      end

      if (zval[z] != '0 && zval[z] < nearest) begin
        nearest = zval[z];
      end
    end
  end

  // Update accumulators; clear them to the current marker at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int z = 0; z < ZONE_COUNT; z++) begin
        acc_min[z]    <= tgztf_pkg::MARKER_RST;
        acc_second[z] <= tgztf_pkg::MARKER_RST;
        acc_count[z]  <= '0;
      end
    end else if (take_cell) begin
      for (int z = 0; z < ZONE_COUNT; z++) begin
        if (in_last) begin
          acc_min[z]    <= marker;
          acc_second[z] <= marker;
          acc_count[z]  <= '0;
        end else begin
          acc_min[z]    <= acc_min_next[z];
          acc_second[z] <= acc_second_next[z];
          acc_count[z]  <= acc_count_next[z];
        end
      end
    end
  end

  // Advance streak and hold flag of the reporting sensor
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        for (int z = 0; z < ZONE_COUNT; z++) begin
          hist_streak[s][z] <= '0;
          hist_ok[s][z]     <= 1'b0;
        end
      end
    end else if (frame_load) begin
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        if (int'(in_sensor) == s) begin
          for (int z = 0; z < ZONE_COUNT; z++) begin
            hist_streak[s][z] <= streak_next[z];
            hist_ok[s][z]     <= ok_next[z];
          end
        end
      end
    end
  end

  // Hold the emitted value and count
  always_ff @(posedge clk) begin
    if (frame_load) begin
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        for (int z = 0; z < ZONE_COUNT; z++) begin
          if (int'(in_sensor) == s && hold_load[z]) begin
            hist_val[s][z] <= zval[z];
            hist_cnt[s][z] <= zcnt[z];
          end
        end
      end
    end
  end

  // Frame buffer control: load on frame end, advance one zone per item sent
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_busy <= 1'b0;
      ob_idx  <= '0;
    end else if (frame_load) begin
      ob_busy <= 1'b1;
      ob_idx  <= '0;
    end else if (ob_busy && m_tready) begin
      if (ob_idx == LAST_ZONE) begin
        ob_busy <= 1'b0;
        ob_idx  <= '0;
      end else begin
        ob_idx <= ob_idx + ZW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_load) begin
      ob_sensor  <= in_sensor;
      ob_nearest <= nearest;
      for (int z = 0; z < ZONE_COUNT; z++) begin
        ob_dist[z] <= zval[z];
        ob_cnt[z]  <= zcnt[z];
      end
    end
  end

  // Drive the result item
  assign m_tvalid = ob_busy;
  assign m_tuser  = ob_sensor;
  assign m_tlast  = ob_idx == LAST_ZONE;
  assign m_tdata  = OUT_W'({ob_nearest, ob_cnt[ob_idx], ob_dist[ob_idx], ob_idx});

endmodule

@@ src/tgztf_checker.sv @@
`timescale 1ns / 1ps

module tgztf_checker #(
  parameter int ZONE_COUNT = 4,
  parameter int SW         = 2,
  parameter int OUT_W      = 40
) (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic [SW-1:0]    m_tuser,
  input logic             m_tlast
);

  localparam int ZW = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
  localparam int DW = tgztf_pkg::DIST_W;
  localparam int NEAR_LO = ZW + DW + tgztf_pkg::COUNT_W;

  logic [ZW-1:0] zone;
  logic [DW-1:0] near;
  assign zone = m_tdata[ZW-1:0];
  assign near = m_tdata[NEAR_LO+DW-1:NEAR_LO];

  // A stalled result item holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("result item changed while stalled");

  // The frame's last item is exactly the last zone
  a_last_zone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (zone == ZW'(ZONE_COUNT - 1))))
    else $error("result_last does not match last zone");

  // Zones of one frame follow without gaps, same sensor and nearest value
  a_zone_seq: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && zone == $past(zone) + ZW'(1) && m_tuser == $past(m_tuser) &&
      near == $past(near))
    else $error("zone sequence broken within frame");

  // A new frame starts at zone zero
  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid || zone == '0)
    else $error("frame does not start at zone zero");

endmodule

bind tof_grid_zone_temporal_filter_unit tgztf_checker #(
  .ZONE_COUNT (ZONE_COUNT),
  .SW         (SW),
  .OUT_W      (OUT_W)
) u_tgztf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int GRID    = 8;
  localparam int ZONES   = 4;
  localparam int SENSORS = 3;
  localparam int SLOTS   = SENSORS * ZONES;
  localparam int IN_BITS  = 32;
  localparam int OUT_BITS = 40;
  localparam int SETTLE   = 10;
  localparam int LIMIT    = 400000;

  // Status codes that never count as a target
  localparam logic [tgztf_pkg::STATUS_W-1:0] STATUS_WEAK      = 8'd4;
  localparam logic [tgztf_pkg::STATUS_W-1:0] STATUS_NO_TARGET = 8'd255;

  typedef enum bit [1:0] {
    SENSOR_LEFT  = 2'd0,
    SENSOR_MID   = 2'd1,
    SENSOR_RIGHT = 2'd2,
    SENSOR_NONE  = 2'd3
  } sensor_t;

  typedef struct {
    sensor_t     sensor;
    bit [2:0]    row;
    bit [2:0]    col;
    bit [15:0]   range_mm;
    bit [7:0]    status;
    bit          last;
  } grid_cell_t;

  typedef struct packed {
    bit [1:0]  sensor;
    bit [1:0]  zone;
    bit [15:0] range_mm;
    bit [4:0]  count;
    bit [15:0] nearest;
    bit        last;
  } zone_res_t;

  logic clk = 1'b0;
  logic rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [IN_BITS-1:0]   s_tdata;
  logic [1:0]           s_tuser;
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OUT_BITS-1:0]  m_tdata;
  logic [1:0]           m_tuser;
  logic                 m_tlast;
  logic                 cfg_we;
  logic [tgztf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tgztf_pkg::CFG_DATA_W-1:0] cfg_data;

  tof_grid_zone_temporal_filter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    // cell_row, cell_col, cell_distance, cell_status
    .s_tdata   (s_tdata),
    // sensor_select
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    // zone_index, zone_distance, zone_valid_count, nearest_mm
    .m_tdata   (m_tdata),
    // sensor_id
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register mirror
  bit [3:0]  floor_rows [SENSORS] = '{tgztf_pkg::SKIP_LEFT_RST, tgztf_pkg::SKIP_MID_RST,
                                      tgztf_pkg::SKIP_RIGHT_RST};
  bit [15:0] marker    = tgztf_pkg::MARKER_RST;
  bit [3:0]  enter_thr = tgztf_pkg::ENTER_THR_RST;
  bit [3:0]  streak_cap = tgztf_pkg::STREAK_CAP_RST;

  // Frame accumulators and per sensor/zone filter state
  bit [15:0] acc_lo   [ZONES] = '{default: tgztf_pkg::MARKER_RST};
  bit [15:0] acc_next [ZONES] = '{default: tgztf_pkg::MARKER_RST};
  bit [4:0]  acc_n    [ZONES] = '{default: 5'd0};
  bit [15:0] held_val [SLOTS];
  bit [4:0]  held_cnt [SLOTS];
  bit [3:0]  streak   [SLOTS] = '{default: 4'd0};
  bit        held_ok  [SLOTS] = '{default: 1'b0};

  zone_res_t expected_zones [$];
  int  fail_count  = 0;
  int  cycle_count = 0;
  int  hold_req    = 0;
  bit  idle_on     = 1'b1;

  always #10 clk = ~clk;

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic bit [3:0] skip_of(input sensor_t s);
    case (s)
      SENSOR_LEFT: return floor_rows[0];
      SENSOR_MID:  return floor_rows[1];
      default:     return floor_rows[2];
    endcase
  endfunction

  function automatic void clear_zones();
    for (int z = 0; z < ZONES; z++) begin
      acc_lo[z]   = marker;
      acc_next[z] = marker;
      acc_n[z]    = 5'd0;
    end
  endfunction

  // Fold one accepted cell into the zones; on the frame's final cell run the
  // temporal filter and queue the four zone results
  function automatic void fold_cell(input grid_cell_t c);
    int        d;
    int        z;
    int        slot;
    bit [15:0] cur;
    bit [15:0] nearest;
    bit [15:0] zval [ZONES];
    bit [4:0]  zcnt [ZONES];
    zone_res_t r;
    d = $signed(c.range_mm);
    z = c.col[2:1];
    if (c.sensor != SENSOR_NONE && c.row >= skip_of(c.sensor) &&
        (c.status == tgztf_pkg::STATUS_VALID || c.status == tgztf_pkg::STATUS_LOW_CONF) &&
        d > 0 && d < int'(marker)) begin
      if (acc_n[z] < tgztf_pkg::COUNT_MAX) acc_n[z]++;
      if (c.range_mm < acc_lo[z]) begin
        acc_next[z] = acc_lo[z];
        acc_lo[z]   = c.range_mm;
      end else if (c.range_mm < acc_next[z]) begin
        acc_next[z] = c.range_mm;
      end
    end
    if (!c.last) return;
    if (c.sensor == SENSOR_NONE) begin
      clear_zones();
      return;
    end
    nearest = marker;
    for (z = 0; z < ZONES; z++) begin
      slot = int'(c.sensor) * ZONES + z;
      if (acc_n[z] == 0) cur = marker;
      else if (acc_n[z] >= 2 && acc_next[z] != marker) cur = acc_next[z];
      else cur = acc_lo[z];
      if (cur != marker) begin
        if (streak[slot] < streak_cap) streak[slot]++;
        if (streak[slot] >= enter_thr) begin
          held_val[slot] = cur;
          held_cnt[slot] = acc_n[z];
          held_ok[slot]  = 1'b1;
          zval[z] = cur;
          zcnt[z] = acc_n[z];
        end else begin
          zval[z] = marker;
          zcnt[z] = 5'd0;
        end
      end else begin
        if (streak[slot] > 0) streak[slot]--;
        if (streak[slot] > 0 && held_ok[slot]) begin
          zval[z] = held_val[slot];
          zcnt[z] = held_cnt[slot];
        end else begin
          zval[z] = marker;
          zcnt[z] = 5'd0;
          held_ok[slot] = 1'b0;
        end
      end
      if (zval[z] > 0 && zval[z] < nearest) nearest = zval[z];
    end
    for (z = 0; z < ZONES; z++) begin
      r.sensor   = c.sensor;
      r.zone     = 2'(z);
      r.range_mm = zval[z];
      r.count    = zcnt[z];
      r.nearest  = nearest;
      r.last     = (z == ZONES - 1);
      expected_zones.push_back(r);
    end
    clear_zones();
  endfunction

  // Compare each zone result with the oldest expected one
  always @(posedge clk) begin
    zone_res_t got;
    zone_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.sensor   = m_tuser;
      got.zone     = m_tdata[1:0];
      got.range_mm = m_tdata[17:2];
      got.count    = m_tdata[22:18];
      got.nearest  = m_tdata[38:23];
      got.last     = m_tlast;
      if (expected_zones.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected zone result: sensor %0d zone %0d dist %0d count %0d",
                   got.sensor, got.zone, got.range_mm, got.count);
        fail_count++;
      end else begin
        want = expected_zones.pop_front();
        if (got != want) begin
          if (fail_count < 10) begin
            $display("zone result mismatch at cycle %0d", cycle_count);
            $display("  expected sensor %0d zone %0d dist %0d count %0d nearest %0d last %0b",
                     want.sensor, want.zone, want.range_mm, want.count, want.nearest,
                     want.last);
            $display("  actual   sensor %0d zone %0d dist %0d count %0d nearest %0d last %0b",
                     got.sensor, got.zone, got.range_mm, got.count, got.nearest, got.last);
          end
          fail_count++;
        end
      end
    end
  end

  // Result sink: random stalls, plus a long hold-off on request
  initial begin
    int n;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
        m_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic grid_cell_t grid_cell(input sensor_t s, input int row, input int col,
                                           input bit [15:0] range_mm, input bit [7:0] status,
                                           input bit last);
    grid_cell_t c;
    c.sensor   = s;
    c.row      = 3'(row);
    c.col      = 3'(col);
    c.range_mm = range_mm;
    c.status   = status;
    c.last     = last;
    return c;
  endfunction

  // Offer one cell, hold it until taken, then predict
  task automatic send_cell(input grid_cell_t c);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, c.status, c.range_mm, c.col, c.row};
    s_tuser  <= c.sensor;
    s_tlast  <= c.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    fold_cell(c);
  endtask

  // Stop offering, wait for every expected result, then let the pipe settle
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_zones.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write one register and leave the write enable high
  task automatic write_reg(input logic [tgztf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      tgztf_pkg::REG_SKIP_LEFT:  floor_rows[0] = val[3:0];
      tgztf_pkg::REG_SKIP_MID:   floor_rows[1] = val[3:0];
      tgztf_pkg::REG_SKIP_RIGHT: floor_rows[2] = val[3:0];
      tgztf_pkg::REG_MARKER:     marker        = val;
      tgztf_pkg::REG_ENTER_THR:  enter_thr     = val[3:0];
      tgztf_pkg::REG_STREAK_CAP: streak_cap    = val[3:0];
      default: ;
    endcase
  endtask

  // Write all six registers; upper bits of the narrow ones carry junk
  task automatic load_setup(input int sl, input int sm, input int sr, input int mk,
                            input int thr, input int cap);
    write_reg(tgztf_pkg::REG_SKIP_LEFT,  {12'($urandom), 4'(sl)});
    write_reg(tgztf_pkg::REG_SKIP_MID,   {12'($urandom), 4'(sm)});
    write_reg(tgztf_pkg::REG_SKIP_RIGHT, {12'($urandom), 4'(sr)});
    write_reg(tgztf_pkg::REG_MARKER,     16'(mk));
    write_reg(tgztf_pkg::REG_ENTER_THR,  {12'($urandom), 4'(thr)});
    write_reg(tgztf_pkg::REG_STREAK_CAP, {12'($urandom), 4'(cap)});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed cells aimed at live zones, some raw noise
  function automatic grid_cell_t random_cell(input sensor_t s, input bit [3:0] live);
    grid_cell_t c;
    int z;
    int lo;
    int hi;
    c.sensor = s;
    c.last   = 1'b0;
    if (live == 4'd0 || $urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1) == 1) c.sensor = sensor_t'($urandom_range(0, 3));
      c.row      = 3'($urandom);
      c.col      = 3'($urandom);
      c.range_mm = 16'($urandom);
      c.status   = 8'($urandom);
      return c;
    end
    do z = $urandom_range(0, ZONES - 1); while (!live[z]);
    c.col = {2'(z), 1'($urandom)};
    lo = skip_of(s);
    if (lo > GRID - 1) lo = 0;
    c.row    = 3'($urandom_range(lo, GRID - 1));
    c.status = ($urandom_range(0, 1) == 1) ? tgztf_pkg::STATUS_VALID
                                           : tgztf_pkg::STATUS_LOW_CONF;
    hi = (marker > 16'd32768) ? 32767 : int'(marker) - 1;
    c.range_mm = (hi >= 1) ? 16'($urandom_range(1, hi)) : 16'($urandom);
    return c;
  endfunction

  // Two valid frames reach the threshold, a third empty one holds
  task automatic test_frame_basics();
    send_cell(grid_cell(SENSOR_LEFT, 2, 0, 16'd100, tgztf_pkg::STATUS_VALID, 1'b0));
    send_cell(grid_cell(SENSOR_LEFT, 3, 1, 16'd50, tgztf_pkg::STATUS_LOW_CONF, 1'b0));
    send_cell(grid_cell(SENSOR_LEFT, 1, 2, 16'd10, tgztf_pkg::STATUS_VALID, 1'b0));
    send_cell(grid_cell(SENSOR_LEFT, 7, 7, 16'h7FFF, tgztf_pkg::STATUS_VALID, 1'b1));
    send_cell(grid_cell(SENSOR_LEFT, 5, 0, 16'hFFFF, tgztf_pkg::STATUS_VALID, 1'b0));
    send_cell(grid_cell(SENSOR_LEFT, 5, 1, 16'h8000, tgztf_pkg::STATUS_VALID, 1'b0));
    send_cell(grid_cell(SENSOR_LEFT, 6, 6, 16'd0, tgztf_pkg::STATUS_VALID, 1'b0));
    send_cell(grid_cell(SENSOR_LEFT, 6, 7, 16'd80, STATUS_WEAK, 1'b0));
    send_cell(grid_cell(SENSOR_LEFT, 4, 0, 16'd1, tgztf_pkg::STATUS_VALID, 1'b1));
    send_cell(grid_cell(SENSOR_LEFT, 0, 0, 16'd20, tgztf_pkg::STATUS_VALID, 1'b1));
    wait_quiet();
  endtask

  // Out-of-range sensor drops its frame; mixed sensors use their own skip rows
  task automatic test_sensor_mixing();
    send_cell(grid_cell(SENSOR_NONE, 7, 3, 16'd90, tgztf_pkg::STATUS_VALID, 1'b0));
    send_cell(grid_cell(SENSOR_NONE, 7, 2, 16'd60, tgztf_pkg::STATUS_VALID, 1'b1));
    send_cell(grid_cell(SENSOR_RIGHT, 1, 4, 16'd300, tgztf_pkg::STATUS_VALID, 1'b0));
    send_cell(grid_cell(SENSOR_LEFT, 1, 4, 16'd30, tgztf_pkg::STATUS_VALID, 1'b0));
    send_cell(grid_cell(SENSOR_MID, 5, 6, 16'd700, STATUS_NO_TARGET, 1'b1));
    wait_quiet();
  endtask

  // Lower the marker between two cells of one frame
  task automatic test_marker_change();
    send_cell(grid_cell(SENSOR_LEFT, 5, 2, 16'd300, tgztf_pkg::STATUS_VALID, 1'b0));
    wait_quiet();
    write_reg(tgztf_pkg::REG_MARKER, 16'd200);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_cell(grid_cell(SENSOR_LEFT, 5, 3, 16'd150, tgztf_pkg::STATUS_VALID, 1'b1));
    wait_quiet();
  endtask

  // Skip every row, zero threshold and cap, tiny markers, unused indexes
  task automatic test_config_extremes();
    load_setup(8, 15, 8, 65535, 0, 0);
    for (int idx = int'(tgztf_pkg::REG_STREAK_CAP) + 1; idx < (1 << tgztf_pkg::CFG_IDX_W);
         idx++)
      write_reg(tgztf_pkg::CFG_IDX_W'(idx), 16'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    send_cell(grid_cell(SENSOR_LEFT, 7, 1, 16'd500, tgztf_pkg::STATUS_VALID, 1'b1));
    wait_quiet();
    load_setup(0, 0, 0, 65535, 0, 0);
    send_cell(grid_cell(SENSOR_LEFT, 0, 1, 16'd500, tgztf_pkg::STATUS_LOW_CONF, 1'b1));
    wait_quiet();
    load_setup(0, 0, 0, 0, 15, 15);
    send_cell(grid_cell(SENSOR_MID, 3, 3, 16'd40, tgztf_pkg::STATUS_VALID, 1'b1));
    wait_quiet();
    load_setup(0, 0, 0, 1, 15, 15);
    send_cell(grid_cell(SENSOR_RIGHT, 3, 5, 16'd1, tgztf_pkg::STATUS_VALID, 1'b1));
    wait_quiet();
  endtask

  // Over thirty cells in one zone saturate its count
  task automatic test_count_saturation();
    load_setup(0, 0, 0, 65535, 1, 3);
    for (int k = 0; k < 34; k++)
      send_cell(grid_cell(SENSOR_RIGHT, $urandom_range(0, GRID - 1), 4 + $urandom_range(0, 1),
                          16'($urandom_range(1, 32767)), tgztf_pkg::STATUS_VALID, k == 33));
    wait_quiet();
  endtask

  // Hold the sink off while one-cell frames keep arriving
  task automatic test_backpressure();
    idle_on  = 1'b0;
    hold_req = 200;
    for (int k = 0; k < 12; k++)
      send_cell(grid_cell(sensor_t'(k % SENSORS), 7, $urandom_range(0, GRID - 1),
                          16'($urandom_range(1, 4000)), tgztf_pkg::STATUS_VALID, 1'b1));
    wait_quiet();
    idle_on = 1'b1;
  endtask

  // Random frames; each sensor's live zones drift from frame to frame
  task automatic test_random_frames(input int n_items);
    int         sent;
    int         len;
    sensor_t    s;
    bit [3:0]   live [SENSORS];
    grid_cell_t c;
    sent = 0;
    live = '{4'hF, 4'hF, 4'hF};
    while (sent < n_items) begin
      s = ($urandom_range(0, 15) == 0) ? SENSOR_NONE : sensor_t'($urandom_range(0, 2));
      if (s != SENSOR_NONE) live[s] ^= 4'($urandom) & 4'($urandom);
      len = $urandom_range(1, 10);
      for (int k = 0; k < len; k++) begin
        c = random_cell(s, (s == SENSOR_NONE) ? 4'hF : live[s]);
        c.last = (k == len - 1);
        send_cell(c);
        sent++;
      end
    end
    wait_quiet();
  endtask

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    s_tlast   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_frame_basics();
    test_sensor_mixing();
    test_marker_change();
    test_config_extremes();
    test_count_saturation();
    test_backpressure();

    load_setup(2, 1, 1, 65535, 2, 2);
    test_random_frames(40);
    load_setup($urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 8),
               $urandom_range(200, 65535), $urandom_range(1, 4), $urandom_range(1, 6));
    test_random_frames(40);
    load_setup(0, 3, 8, $urandom_range(500, 2000), 3, 15);
    test_random_frames(30);

    // Last stretch without idling
    idle_on = 1'b0;
    load_setup(1, 1, 1, 65535, 1, 4);
    test_random_frames(30);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
